[hdl/ubx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_pkg
// Shared types and constants of the acknowledge packet receiver.
// ----------------------------------------------------------------------------
package ubx_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;
	localparam logic [7:0] ACK_CLASS   = 8'h05;

	localparam int unsigned POS_W = 4;
	localparam int unsigned CFG_W = 16;

	localparam logic [7:0]  RST_EXPECTED_CLASS   = 8'd6;
	localparam logic [7:0]  RST_EXPECTED_MESSAGE = 8'd0;
	localparam logic [15:0] RST_TIMEOUT_MS       = 16'd1500;
	localparam logic [15:0] ELAPSED_MAX          = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TIMEOUT  = 2'd1,
		ST_NAK      = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_CLASS   = 2'd0,
		CFG_MESSAGE = 2'd1,
		CFG_TIMEOUT = 2'd2,
		CFG_NONE    = 2'd3
	} cfg_idx_t;

	typedef enum logic [POS_W-1:0] {
		POS_SYNC1   = 4'd0,
		POS_SYNC2   = 4'd1,
		POS_CLASS   = 4'd2,
		POS_KIND    = 4'd3,
		POS_LEN1    = 4'd4,
		POS_LEN2    = 4'd5,
		POS_ECLASS  = 4'd6,
		POS_EMSG    = 4'd7,
		POS_CK_A    = 4'd8,
		POS_CK_B    = 4'd9
	} pos_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] rx_byte;
	} ubx_beat_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} ubx_result_t;

endpackage

[hdl/ubx_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_in_stage
// Input register: holds one accepted beat until the core consumes it.
// ----------------------------------------------------------------------------
module ubx_in_stage
	import ubx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      [7:0] s_tdata,  // rx_byte[7:0]
	input  logic      [1:0] s_tuser,  // operation[1:0]
	input  logic      advance,
	output logic      valid_s1,
	output ubx_beat_t beat_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1.op      <= op_t'(s_tuser);
			beat_s1.rx_byte <= s_tdata;
		end
	end

endmodule

[hdl/ubx_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_core
// Packet state, checksum, timeout counter and configuration registers.
// ----------------------------------------------------------------------------
module ubx_core
	import ubx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic        process,
	input  ubx_beat_t   beat_s1,
	output ubx_result_t result
);

	logic [7:0]       exp_class_q, exp_msg_q;
	logic [15:0]      timeout_q;

	logic             waiting_q, waiting_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       kind_q, kind_d;
	logic [7:0]       eclass_q, eclass_d;
	logic [7:0]       emsg_q, emsg_d;
	logic [7:0]       ck_a_q, ck_a_d;
	logic [7:0]       ck_b_q, ck_b_d;
	logic [7:0]       first_ck_q, first_ck_d;
	logic [15:0]      elapsed_q, elapsed_d;

	logic [7:0]       b;
	logic [7:0]       sum_a, sum_b;

	assign b     = beat_s1.rx_byte;
	assign sum_a = ck_a_q + b;
	assign sum_b = ck_b_q + sum_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_class_q <= RST_EXPECTED_CLASS;
			exp_msg_q   <= RST_EXPECTED_MESSAGE;
			timeout_q   <= RST_TIMEOUT_MS;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CLASS:   exp_class_q <= cfg_data[7:0];
				CFG_MESSAGE: exp_msg_q   <= cfg_data[7:0];
				CFG_TIMEOUT: timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		waiting_d     = waiting_q;
		pos_d         = pos_q;
		kind_d        = kind_q;
		eclass_d      = eclass_q;
		emsg_d        = emsg_q;
		ck_a_d        = ck_a_q;
		ck_b_d        = ck_b_q;
		first_ck_d    = first_ck_q;
		elapsed_d     = elapsed_q;
		result.valid  = 1'b0;
		result.status = ST_OK;

		if (beat_s1.op == OP_START) begin
			waiting_d  = 1'b1;
			pos_d      = POS_SYNC1;
			kind_d     = '0;
			eclass_d   = '0;
			emsg_d     = '0;
			ck_a_d     = '0;
			ck_b_d     = '0;
			first_ck_d = '0;
			elapsed_d  = '0;
		end else if (waiting_q && beat_s1.op == OP_TICK) begin
			if (elapsed_q != ELAPSED_MAX) begin
				elapsed_d = elapsed_q + 16'd1;
			end
			if (elapsed_d >= timeout_q) begin
				result.valid  = 1'b1;
				result.status = ST_TIMEOUT;
			end
		end else if (waiting_q && beat_s1.op == OP_BYTE) begin
			// A byte that arrives once the elapsed time has reached the limit ends the wait with a timeout.
			if (elapsed_q >= timeout_q) begin
				result.valid  = 1'b1;
				result.status = ST_TIMEOUT;
			end else begin
				case (pos_t'(pos_q))
					POS_SYNC1: begin
						if (b == SYNC_FIRST) pos_d = POS_SYNC2;
					end
					POS_SYNC2: begin
						if (b == SYNC_SECOND) pos_d = POS_CLASS;
					end
					POS_CLASS: begin
						if (b == ACK_CLASS) begin
							ck_a_d = sum_a;
							ck_b_d = sum_b;
							pos_d  = POS_KIND;
						end
					end
					POS_KIND: begin
						kind_d = b;
						ck_a_d = sum_a;
						ck_b_d = sum_b;
						pos_d  = POS_LEN1;
					end
					POS_LEN1, POS_LEN2: begin
						ck_a_d = sum_a;
						ck_b_d = sum_b;
						pos_d  = pos_q + 4'd1;
					end
					POS_ECLASS: begin
						eclass_d = b;
						ck_a_d   = sum_a;
						ck_b_d   = sum_b;
						pos_d    = POS_EMSG;
					end
					POS_EMSG: begin
						emsg_d = b;
						ck_a_d = sum_a;
						ck_b_d = sum_b;
						pos_d  = POS_CK_A;
					end
					POS_CK_A: begin
						first_ck_d = b;
						pos_d      = POS_CK_B;
					end
					default: begin
						result.valid = 1'b1;
						pos_d        = POS_SYNC1;
						if (kind_q == 8'd0) begin
							result.status = ST_NAK;
						end else if (eclass_q == exp_class_q && emsg_q == exp_msg_q &&
						             ck_a_q == first_ck_q && ck_b_q == b) begin
							result.status = ST_OK;
						end else begin
							result.status = ST_MISMATCH;
						end
					end
				endcase
			end
		end

		if (result.valid) begin
			waiting_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q  <= 1'b0;
			pos_q      <= POS_SYNC1;
			kind_q     <= '0;
			eclass_q   <= '0;
			emsg_q     <= '0;
			ck_a_q     <= '0;
			ck_b_q     <= '0;
			first_ck_q <= '0;
			elapsed_q  <= '0;
		end else if (process) begin
			waiting_q  <= waiting_d;
			pos_q      <= pos_d;
			kind_q     <= kind_d;
			eclass_q   <= eclass_d;
			emsg_q     <= emsg_d;
			ck_a_q     <= ck_a_d;
			ck_b_q     <= ck_b_d;
			first_ck_q <= first_ck_d;
			elapsed_q  <= elapsed_d;
		end
	end

endmodule

[hdl/ubx_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_out_stage
// Result register facing the output stream.
// ----------------------------------------------------------------------------
module ubx_out_stage
	import ubx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  ubx_result_t result,
	output logic        slot_free,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // status[1:0], zeros above
);

	status_t status_q;

	assign slot_free = !m_tvalid || m_tready;
	assign m_tdata   = {6'd0, status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load && result.valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && result.valid) begin
			status_q <= result.status;
		end
	end

endmodule

[hdl/ubx_ack_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_ack_receiver
// Watches received bytes for a ten-byte acknowledge packet and reports status.
//
//  Channel   Direction  Signals                        Content
//  s_*       in         s_tvalid s_tready s_tdata s_tuser   event, byte
//  m_*       out        m_tvalid m_tready m_tdata           status
//  cfg_*     in         cfg_we cfg_index cfg_data           register write
//
// One beat per cycle is accepted while s_tready is high; a status travels from the beat
// that caused it through the input register and then the result register.
// Reset clears the packet state and loads the register defaults; the block is
// ready as soon as reset is released. While a status waits on m_tready the
// input register holds its beat, and s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module ubx_ack_receiver
	import ubx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // rx_byte[7:0]
	input  logic [1:0]        s_tuser,   // operation[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // status[1:0], zeros above
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	logic        valid_s1;
	ubx_beat_t   beat_s1;
	logic        slot_free;
	logic        advance;
	ubx_result_t result;

	assign advance = valid_s1 && slot_free;

	ubx_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	ubx_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.process   (advance),
		.beat_s1   (beat_s1),
		.result    (result)
	);

	ubx_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.slot_free (slot_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

[hdl/ubx_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_checker
// Port-level checks of the acknowledge packet receiver.
// ----------------------------------------------------------------------------
module ubx_checker
	import ubx_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A stalled status beat must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("status beat changed while stalled");

	// Input back-pressure only happens while a status is stuck at the output.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// A new status always follows an accepted beat that went through the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("status appeared without a causing beat");

	// Padding bits above the status stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:2] == 6'd0)
		else $error("nonzero padding in status beat");

endmodule

bind ubx_ack_receiver ubx_checker u_ubx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[bench/ubx_ack_receiver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_ack_receiver_tb
// Self-checking bench for the acknowledge packet receiver.
//
// A scoreboard class tracks the wait state, the packet position, the running
// Fletcher sums and the elapsed milliseconds. From every accepted input beat
// it works out the status the block owes. Each status beat is checked against
// the oldest one that is owed. The stimulus starts with a short directed part.
// It continues with mostly well-formed packets with random content, mixed
// with header noise, ticks, restarts and cut-off packets. Six register
// settings and three idling profiles are used.
// ----------------------------------------------------------------------------
import ubx_pkg::*;

class ack_status_board;
	logic [7:0]  want_class;
	logic [7:0]  want_msg;
	logic [15:0] limit_ms;

	bit          armed;
	pos_t        pos;
	logic [7:0]  kind;
	logic [7:0]  echo_cls;
	logic [7:0]  echo_msg;
	logic [7:0]  sum_a;
	logic [7:0]  sum_b;
	logic [7:0]  rx_ck_a;
	logic [15:0] elapsed;

	status_t     status_due[$];
	int          errors;
	int          beats;
	int          live_beats;
	int          status_seen[4];

	function new();
		want_class = RST_EXPECTED_CLASS;
		want_msg   = RST_EXPECTED_MESSAGE;
		limit_ms   = RST_TIMEOUT_MS;
		armed      = 1'b0;
		clear();
	endfunction

	function void clear();
		pos      = POS_SYNC1;
		kind     = '0;
		echo_cls = '0;
		echo_msg = '0;
		sum_a    = '0;
		sum_b    = '0;
		rx_ck_a  = '0;
		elapsed  = '0;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		case (idx)
			CFG_CLASS:   want_class = val[7:0];
			CFG_MESSAGE: want_msg   = val[7:0];
			CFG_TIMEOUT: limit_ms   = val;
			default: ;
		endcase
	endfunction

	function void add_sum(logic [7:0] b);
		sum_a = sum_a + b;
		sum_b = sum_b + sum_a;
	endfunction

	// Returns 1 when the tenth byte closes the packet.
	function bit take_byte(logic [7:0] b, output status_t st);
		st = ST_OK;
		case (pos)
			POS_SYNC1:  if (b == SYNC_FIRST) pos = POS_SYNC2;
			POS_SYNC2:  if (b == SYNC_SECOND) pos = POS_CLASS;
			POS_CLASS:  if (b == ACK_CLASS) begin
				add_sum(b);
				pos = POS_KIND;
			end
			POS_KIND: begin
				kind = b;
				add_sum(b);
				pos = POS_LEN1;
			end
			POS_LEN1: begin
				add_sum(b);
				pos = POS_LEN2;
			end
			POS_LEN2: begin
				add_sum(b);
				pos = POS_ECLASS;
			end
			POS_ECLASS: begin
				echo_cls = b;
				add_sum(b);
				pos = POS_EMSG;
			end
			POS_EMSG: begin
				echo_msg = b;
				add_sum(b);
				pos = POS_CK_A;
			end
			POS_CK_A: begin
				rx_ck_a = b;
				pos = POS_CK_B;
			end
			default: begin
				if (kind == 8'd0)
					st = ST_NAK;
				else if (echo_cls == want_class && echo_msg == want_msg &&
				         sum_a == rx_ck_a && sum_b == b)
					st = ST_OK;
				else
					st = ST_MISMATCH;
				pos = POS_SYNC1;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function void note_beat(op_t op, logic [7:0] b);
		status_t st;
		bit      done;
		done = 1'b0;
		st   = ST_OK;
		beats++;
		if (op == OP_START || (armed && op != OP_RSVD))
			live_beats++;
		case (op)
			OP_START: begin
				clear();
				armed = 1'b1;
			end
			OP_TICK: if (armed) begin
				if (elapsed != ELAPSED_MAX)
					elapsed = elapsed + 16'd1;
				if (elapsed >= limit_ms) begin
					st   = ST_TIMEOUT;
					done = 1'b1;
				end
			end
			OP_BYTE: if (armed) begin
				// A lowered limit makes even a byte end the wait.
				if (elapsed >= limit_ms) begin
					st   = ST_TIMEOUT;
					done = 1'b1;
				end else begin
					done = take_byte(b, st);
				end
			end
			default: ;
		endcase
		if (done) begin
			armed = 1'b0;
			status_due.push_back(st);
		end
	endfunction

	function void check_status(logic [7:0] data);
		status_t want;
		status_t got;
		got = status_t'(data[1:0]);
		if (status_due.size() == 0) begin
			$error("status beat with none owed: status %s", got.name());
			errors++;
			return;
		end
		want = status_due.pop_front();
		status_seen[int'(want)]++;
		if (got !== want) begin
			$error("status: expected %s, actual %s", want.name(), got.name());
			errors++;
		end
		if (data[7:2] !== 6'd0) begin
			$error("tdata padding: expected 0, actual %0d", data[7:2]);
			errors++;
		end
	endfunction

	function int pending();
		return status_due.size();
	endfunction
endclass

module ubx_ack_receiver_tb;

	localparam int SETTLE        = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 3000;
	localparam int BEATS_PER_SET = 200;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic [1:0]       s_tuser = OP_START;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = CFG_NONE;
	logic [CFG_W-1:0] cfg_data = '0;

	ack_status_board sb = new();

	int send_idle = 0;
	int recv_idle = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_cycles = 0;
	int settings_used = 0;

	ubx_ack_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // rx_byte[7:0]
		.s_tuser   (s_tuser),    // operation[1:0]
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // status[1:0], zeros above
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver side: random back-pressure, or a long hold-off on request.
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_beat(op_t'(s_tuser), s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_status(m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_beat(op_t op, logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops offering beats until every owed status is back and the
	// pipeline has had time to swallow beats that owe nothing.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write.
	task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic load_regs(logic [7:0] cls, logic [7:0] msg, logic [15:0] tmo);
		// Upper bits of the 8-bit registers carry junk on purpose.
		cfg_write(CFG_CLASS, {8'($urandom), cls});
		cfg_write(CFG_MESSAGE, {8'($urandom), msg});
		cfg_write(CFG_TIMEOUT, tmo);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [15:0] ack_checksum(logic [7:0] kind, logic [7:0] l1,
			logic [7:0] l2, logic [7:0] cls, logic [7:0] msg);
		logic [7:0] body[6];
		logic [7:0] a;
		logic [7:0] b;
		body = '{ACK_CLASS, kind, l1, l2, cls, msg};
		a = '0;
		b = '0;
		foreach (body[i]) begin
			a = a + body[i];
			b = b + a;
		end
		return {b, a};
	endfunction

	task automatic random_packet();
		logic [7:0]  pkt[10];
		logic [15:0] ck;
		logic [7:0]  w;
		int          cut;
		int          kind_sel;
		kind_sel = $urandom_range(15);
		if (kind_sel == 0) begin
			// Pure noise: any operation, any byte.
			repeat (15) send_beat(op_t'($urandom_range(3)), 8'($urandom));
			return;
		end
		send_beat(OP_START, 8'($urandom));
		if (kind_sel == 1 && sb.limit_ms <= 40) begin
			// Let the wait run out, with a stray byte now and then.
			repeat (sb.limit_ms) begin
				if ($urandom_range(3) == 0)
					send_beat(OP_BYTE, 8'($urandom));
				send_beat(OP_TICK, 8'($urandom));
			end
			return;
		end
		pkt[0] = SYNC_FIRST;
		pkt[1] = SYNC_SECOND;
		pkt[2] = ACK_CLASS;
		pkt[3] = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom);
		pkt[4] = ($urandom_range(1) == 0) ? 8'd2 : 8'($urandom);
		pkt[5] = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom);
		pkt[6] = ($urandom_range(3) == 0) ? 8'($urandom) : sb.want_class;
		pkt[7] = ($urandom_range(3) == 0) ? 8'($urandom) : sb.want_msg;
		ck = ack_checksum(pkt[3], pkt[4], pkt[5], pkt[6], pkt[7]);
		pkt[8] = ck[7:0];
		pkt[9] = ck[15:8];
		case ($urandom_range(7))
			0: pkt[8] = pkt[8] ^ 8'($urandom_range(255, 1));
			1: pkt[9] = pkt[9] ^ 8'($urandom_range(255, 1));
			default: ;
		endcase
		// A cut-off packet is followed by a fresh start, which restarts the wait.
		cut = ($urandom_range(14) == 0) ? $urandom_range(9) : 10;
		for (int i = 0; i < cut; i++) begin
			while ($urandom_range(11) == 0) begin
				case ($urandom_range(2))
					0: send_beat(OP_TICK, 8'($urandom));
					1: send_beat(OP_RSVD, 8'($urandom));
					default: begin
						if (i <= 2) begin
							// A wrong header byte holds the position.
							w = 8'($urandom);
							if (w == pkt[i])
								w = ~w;
							send_beat(OP_BYTE, w);
						end else begin
							send_beat(OP_TICK, 8'($urandom));
						end
					end
				endcase
			end
			send_beat(OP_BYTE, pkt[i]);
		end
	endtask

	initial begin
		logic [15:0] ck;
		int          beat_mark;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 36;
		recv_idle = 62;

		// Events while idle are ignored.
		send_beat(OP_TICK, 8'hFF);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_RSVD, 8'h00);

		// Good packet under reset registers, with wrong header bytes mixed in.
		ck = ack_checksum(8'hFF, 8'hFF, 8'h00, RST_EXPECTED_CLASS, RST_EXPECTED_MESSAGE);
		send_beat(OP_START, 8'h00);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, SYNC_FIRST);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, SYNC_SECOND);
		send_beat(OP_BYTE, 8'h06);
		send_beat(OP_BYTE, ACK_CLASS);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, RST_EXPECTED_CLASS);
		send_beat(OP_BYTE, RST_EXPECTED_MESSAGE);
		send_beat(OP_BYTE, ck[7:0]);
		send_beat(OP_BYTE, ck[15:8]);

		// Limit lowered below the elapsed time: the next byte times out.
		send_beat(OP_START, 8'h00);
		send_beat(OP_TICK, 8'h00);
		send_beat(OP_TICK, 8'h00);
		drain();
		cfg_write(CFG_NONE, 16'hFFFF);
		cfg_write(CFG_TIMEOUT, 16'd1);
		cfg_we <= 1'b0;
		send_beat(OP_BYTE, SYNC_FIRST);

		// Restart while waiting, then a tick at a limit of 1.
		send_beat(OP_START, 8'hFF);
		send_beat(OP_START, 8'h00);
		send_beat(OP_TICK, 8'h00);
		drain();

		// Long receiver hold-off while timeouts keep coming: the block fills up.
		hold_seq++;
		repeat (8) begin
			send_beat(OP_START, 8'($urandom));
			send_beat(OP_TICK, 8'($urandom));
		end
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin send_idle = 36; recv_idle = 62; end
				2: begin send_idle = 62; recv_idle = 36; end
				4: begin send_idle = 0;  recv_idle = 0;  end
				default: ;
			endcase
			drain();
			case (ph)
				0: load_regs(8'h00, 8'hFF, 16'd1);
				1: load_regs(8'hFF, 8'h00, 16'd8);
				2: load_regs(8'($urandom), 8'($urandom), 16'($urandom_range(30, 2)));
				3: load_regs(ACK_CLASS, SYNC_SECOND, 16'd3);
				4: load_regs(8'h06, 8'h01, 16'hFFFF);
				default: load_regs(8'($urandom), 8'($urandom), RST_TIMEOUT_MS);
			endcase
			beat_mark = sb.beats;
			while (sb.beats - beat_mark < BEATS_PER_SET)
				random_packet();
		end

		drain();
		$display("Covered %0d beats (%0d while waiting) over %0d register settings.",
			sb.beats, sb.live_beats, settings_used);
		$display("Statuses checked: ok %0d, timeout %0d, nak %0d, mismatch %0d.",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
